[rtl/rbh_pkg.sv]
package rbh_pkg;

  // Field and datapath widths.
  localparam int unsigned Axes     = 3;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracW    = 16;
  localparam int unsigned NumW     = CoordW + 1 + FracW;  // |plane - origin| << 16
  localparam int unsigned DivLat   = NumW + 1;            // one bit per stage plus fixup
  localparam int unsigned PipeDepth = 1 + DivLat + 3;     // register stages start to done

  // Distance marker for an axis that names no candidate plane (-1.0).
  localparam logic signed [CoordW-1:0] TNone = 32'shFFFF_0000;
  localparam logic signed [CoordW-1:0] TMax  = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] TMin  = 32'sh8000_0000;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [NumW-1:0]          num_t;
  typedef logic [CoordW-1:0]        den_t;

  // Operands that travel alongside the divider.
  typedef struct packed {
    coord_t [Axes-1:0] org;
    coord_t [Axes-1:0] dir;
    coord_t [Axes-1:0] lo;
    coord_t [Axes-1:0] hi;
    logic   [Axes-1:0] use_t;
    logic              in_box;
  } side_t;

  // One restoring division step: returns {quotient bit, next remainder}.
  function automatic logic [CoordW:0] div_step(input den_t rem, input logic abit,
                                               input den_t den);
    logic [CoordW:0] trial;
    logic [CoordW:0] diff;
    trial = {rem, abit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {1'b1, diff[CoordW-1:0]};
    end
    return {1'b0, trial[CoordW-1:0]};
  endfunction

endpackage

[rtl/rbh_classify.sv]
module rbh_classify import rbh_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  coord_t org_i [Axes],
  input  coord_t dir_i [Axes],
  input  coord_t lo_i  [Axes],
  input  coord_t hi_i  [Axes],
  output logic   valid_o,
  output side_t  side_o,
  output num_t   num_o [Axes],
  output den_t   den_o [Axes],
  output logic   neg_o [Axes]
);

  side_t side_d;
  num_t  num_d [Axes];
  den_t  den_d [Axes];
  logic  neg_d [Axes];
  logic  valid_q;
  side_t side_q;
  num_t  num_q [Axes];
  den_t  den_q [Axes];
  logic  neg_q [Axes];

  // Class each axis against its slab and set up the plane distance operands.
  always_comb begin
    logic below, above;
    logic signed [CoordW:0] plane, diff;
    logic [CoordW:0] mag;
    side_d.in_box = 1'b1;
    for (int i = 0; i < Axes; i++) begin
      below = org_i[i] < lo_i[i];
      above = !below && (org_i[i] > hi_i[i]);
      plane = below ? {lo_i[i][CoordW-1], lo_i[i]} : {hi_i[i][CoordW-1], hi_i[i]};
      diff  = plane - {org_i[i][CoordW-1], org_i[i]};
      mag   = diff[CoordW] ? (CoordW+1)'(-diff) : diff;
      num_d[i] = {mag, {FracW{1'b0}}};
      den_d[i] = dir_i[i][CoordW-1] ? den_t'(-dir_i[i]) : den_t'(dir_i[i]);
      neg_d[i] = diff[CoordW] ^ dir_i[i][CoordW-1];
      side_d.org[i]   = org_i[i];
      side_d.dir[i]   = dir_i[i];
      side_d.lo[i]    = lo_i[i];
      side_d.hi[i]    = hi_i[i];
      side_d.use_t[i] = (below || above) && (dir_i[i] != '0);
      if (below || above) begin
        side_d.in_box = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d;
    num_q  <= num_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign neg_o   = neg_q;

endmodule

[rtl/rbh_divider.sv]
module rbh_divider import rbh_pkg::*; (
  input  logic   clk_i,
  input  num_t   num_i,
  input  den_t   den_i,
  input  logic   neg_i,
  output coord_t t_o
);

  den_t rem_q [NumW];
  num_t num_q [NumW];
  num_t quo_q [NumW];
  den_t den_q [NumW];
  logic neg_q [NumW];
  coord_t t_q;

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < NumW; k++) begin : g_stage
    den_t rem_prev, den_prev;
    num_t num_prev, quo_prev;
    logic neg_prev;
    logic [CoordW:0] step;
    if (k == 0) begin : g_first
      assign rem_prev = '0;
      assign num_prev = num_i;
      assign quo_prev = '0;
      assign den_prev = den_i;
      assign neg_prev = neg_i;
    end else begin : g_next
      assign rem_prev = rem_q[k-1];
      assign num_prev = num_q[k-1];
      assign quo_prev = quo_q[k-1];
      assign den_prev = den_q[k-1];
      assign neg_prev = neg_q[k-1];
    end
    assign step = div_step(rem_prev, num_prev[NumW-1], den_prev);
    always_ff @(posedge clk_i) begin
      rem_q[k] <= step[CoordW-1:0];
      num_q[k] <= {num_prev[NumW-2:0], 1'b0};
      quo_q[k] <= {quo_prev[NumW-2:0], step[CoordW]};
      den_q[k] <= den_prev;
      neg_q[k] <= neg_prev;
    end
  end

  // Apply the sign with rounding toward minus infinity, then saturate.
  always_ff @(posedge clk_i) begin
    logic [NumW:0] mag;
    mag = {1'b0, quo_q[NumW-1]} + (NumW+1)'(rem_q[NumW-1] != '0);
    if (!neg_q[NumW-1]) begin
      if (quo_q[NumW-1][NumW-1:CoordW-1] != '0) begin
        t_q <= TMax;
      end else begin
        t_q <= coord_t'(quo_q[NumW-1][CoordW-1:0]);
      end
    end else begin
      if (mag > (NumW+1)'({1'b1, {(CoordW-1){1'b0}}})) begin
        t_q <= TMin;
      end else begin
        t_q <= coord_t'(-mag[CoordW-1:0]);
      end
    end
  end

  assign t_o = t_q;

endmodule

[rtl/rbh_resolve.sv]
module rbh_resolve import rbh_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  side_t  side_i,
  input  coord_t t_i [Axes],
  output logic   done_o,
  output logic   hit_o,
  output logic   starts_inside_o
);

  logic   v1_q, v2_q, done_q;
  side_t  side1_q, side2_q;
  logic [1:0] best1_q, best2_q;
  coord_t tbest_q;
  logic   tneg_q;
  logic signed [2*CoordW-1:0] prod_q [Axes];
  logic   hit_q, inside_q;
  logic [1:0] best_d;
  coord_t tbest_d;

  // Pick the largest plane distance; the lower axis wins a tie.
  always_comb begin
    coord_t tt [Axes];
    for (int i = 0; i < Axes; i++) begin
      tt[i] = side_i.use_t[i] ? t_i[i] : TNone;
    end
    best_d  = 2'd0;
    tbest_d = tt[0];
    if (tbest_d < tt[1]) begin
      best_d  = 2'd1;
      tbest_d = tt[1];
    end
    if (tbest_d < tt[2]) begin
      best_d  = 2'd2;
      tbest_d = tt[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  // Selection, product and compare stages.
  always_ff @(posedge clk_i) begin
    logic signed [CoordW+FracW:0] c;
    logic all_ok;
    side1_q <= side_i;
    best1_q <= best_d;
    tbest_q <= tbest_d;

    side2_q <= side1_q;
    best2_q <= best1_q;
    tneg_q  <= tbest_q[CoordW-1];
    for (int i = 0; i < Axes; i++) begin
      prod_q[i] <= tbest_q * side1_q.dir[i];
    end

    all_ok = 1'b1;
    for (int i = 0; i < Axes; i++) begin
      c = {{(FracW+1){side2_q.org[i][CoordW-1]}}, side2_q.org[i]}
          + {prod_q[i][2*CoordW-1], prod_q[i][2*CoordW-1:FracW]};
      if (best2_q != 2'(i)) begin
        if (c < $signed({{(FracW+1){side2_q.lo[i][CoordW-1]}}, side2_q.lo[i]}) ||
            c > $signed({{(FracW+1){side2_q.hi[i][CoordW-1]}}, side2_q.hi[i]})) begin
          all_ok = 1'b0;
        end
      end
    end
    inside_q <= side2_q.in_box;
    hit_q    <= side2_q.in_box || (!tneg_q && all_ok);
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign starts_inside_o = inside_q;

endmodule

[rtl/ray_box_hit_test.sv]
// Ray versus axis-aligned box test, one transfer accepted every cycle.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// The plane distance divider makes up most of the pipeline: 49 quotient stages and a sign stage.
// Reset clears all valid bits at once; results under way are dropped.
module ray_box_hit_test import rbh_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  output logic   busy,
  input  coord_t origin_x_i,
  input  coord_t origin_y_i,
  input  coord_t origin_z_i,
  input  coord_t dir_x_i,
  input  coord_t dir_y_i,
  input  coord_t dir_z_i,
  input  coord_t box_min_x_i,
  input  coord_t box_min_y_i,
  input  coord_t box_min_z_i,
  input  coord_t box_max_x_i,
  input  coord_t box_max_y_i,
  input  coord_t box_max_z_i,
  output logic   done_o,
  output logic   hit_o,
  output logic   starts_inside_o
);

  coord_t org [Axes], dir [Axes], lo [Axes], hi [Axes];
  logic   cls_valid;
  side_t  cls_side;
  num_t   cls_num [Axes];
  den_t   cls_den [Axes];
  logic   cls_neg [Axes];
  coord_t t [Axes];
  logic   v_q [DivLat];
  side_t  side_q [DivLat];

  assign busy = 1'b0;

  assign org = '{origin_x_i, origin_y_i, origin_z_i};
  assign dir = '{dir_x_i, dir_y_i, dir_z_i};
  assign lo  = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign hi  = '{box_max_x_i, box_max_y_i, box_max_z_i};

  rbh_classify u_classify (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .org_i   (org),
    .dir_i   (dir),
    .lo_i    (lo),
    .hi_i    (hi),
    .valid_o (cls_valid),
    .side_o  (cls_side),
    .num_o   (cls_num),
    .den_o   (cls_den),
    .neg_o   (cls_neg)
  );

  // One divider per axis.
  for (genvar i = 0; i < Axes; i++) begin : g_div
    rbh_divider u_divider (
      .clk_i,
      .num_i (cls_num[i]),
      .den_i (cls_den[i]),
      .neg_i (cls_neg[i]),
      .t_o   (t[i])
    );
  end

  // Operands and valid bits delayed to meet the divider results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivLat; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      v_q[0] <= cls_valid;
      for (int k = 1; k < DivLat; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= cls_side;
    for (int k = 1; k < DivLat; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  rbh_resolve u_resolve (
    .clk_i,
    .rst_ni,
    .valid_i         (v_q[DivLat-1]),
    .side_i          (side_q[DivLat-1]),
    .t_i             (t),
    .done_o,
    .hit_o,
    .starts_inside_o
  );

endmodule

[rtl/rbh_checker.sv]
module rbh_checker import rbh_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic hit_o,
  input logic starts_inside_o
);

  localparam int unsigned CntW = $clog2(PipeDepth + 2);
  logic [CntW-1:0] since_rst_q;

  // Cycles since reset, held once the pipeline has filled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_rst_q <= '0;
    end else if (since_rst_q != CntW'(PipeDepth + 1)) begin
      since_rst_q <= since_rst_q + 1'b1;
    end
  end

  // The block never holds off a start transfer.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // Every accepted item gives exactly one result a fixed latency later.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    since_rst_q == CntW'(PipeDepth + 1) |-> done_o == $past(start, PipeDepth))
    else $error("result strobe out of step with start transfers");

  // An origin inside the box is always a hit.
  a_inside_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && starts_inside_o |-> hit_o)
    else $error("inside origin reported as miss");

  // No result can appear before the pipeline has filled after reset.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    since_rst_q < CntW'(PipeDepth) |-> !done_o)
    else $error("result strobe before any item could finish");

endmodule

bind ray_box_hit_test rbh_checker u_rbh_checker (
  .clk_i,
  .rst_ni,
  .start,
  .busy,
  .done_o,
  .hit_o,
  .starts_inside_o
);
